/* sv/afade_pkg.sv */
package afade_pkg;

	// Sample field width and the bits of it that carry the signed sample
	localparam int DATA_W      = 32;
	localparam int SAMPLE_BITS = 32;

	// Configuration request
	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_STREAM_LENGTH   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FADE_IN_LENGTH  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_FADE_OUT_LENGTH = CFG_IDX_W'(2);

	// One bit per step in the serial multiply and divide
	localparam int STEPS = DATA_W;
	localparam int CNT_W = $clog2(STEPS);

	typedef struct packed {
		logic load;
		logic step;
	} afade_ctl_t;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_FADE_A = 9'b000000010,
		ST_FADE_B = 9'b000000100,
		ST_FADE_C = 9'b000001000,
		ST_FADE_D = 9'b000010000,
		ST_MUL    = 9'b000100000,
		ST_SEL    = 9'b001000000,
		ST_DIV    = 9'b010000000,
		ST_DONE   = 9'b100000000
	} afade_state_t;

endpackage

/* sv/afade_if.sv */
interface afade_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [afade_pkg::CFG_IDX_W-1:0] index;
	logic [afade_pkg::DATA_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

interface afade_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [afade_pkg::DATA_W-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface afade_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [afade_pkg::DATA_W-1:0] sample_out;
	logic                               last;

	modport source (output valid, output sample_out, output last, input ready);
	modport sink (input valid, input sample_out, input last, output ready);
endinterface

/* sv/afade_mul.sv */
module afade_mul (
	input  logic                             clk,
	input  afade_pkg::afade_ctl_t            ctl,
	input  logic [afade_pkg::DATA_W-1:0]     mcand,
	input  logic [afade_pkg::DATA_W-1:0]     mplier,
	output logic [2*afade_pkg::DATA_W-1:0]   product
);

	logic [afade_pkg::DATA_W-1:0]   mcand_q;
	logic [2*afade_pkg::DATA_W-1:0] acc_q;
	logic [afade_pkg::DATA_W:0]     sum;

	// Multiplier sits in the low half and drains out one bit a step
	always_comb begin
		sum = {1'b0, acc_q[2*afade_pkg::DATA_W-1:afade_pkg::DATA_W]}
			+ (acc_q[0] ? {1'b0, mcand_q} : '0);
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mcand_q <= mcand;
			acc_q   <= {{afade_pkg::DATA_W{1'b0}}, mplier};
		end else if (ctl.step) begin
			acc_q <= {sum, acc_q[afade_pkg::DATA_W-1:1]};
		end
	end

	assign product = acc_q;

endmodule

/* sv/afade_div.sv */
module afade_div (
	input  logic                             clk,
	input  afade_pkg::afade_ctl_t            ctl,
	input  logic [2*afade_pkg::DATA_W-1:0]   dividend,
	input  logic [afade_pkg::DATA_W-1:0]     divisor,
	output logic [afade_pkg::DATA_W-1:0]     quotient
);

	logic [afade_pkg::DATA_W-1:0] rem_q;
	logic [afade_pkg::DATA_W-1:0] quo_q;
	logic [afade_pkg::DATA_W-1:0] den_q;
	logic [afade_pkg::DATA_W+1:0] diff;
	logic                         borrow;

	// Upper half of the dividend is below the divisor, so the quotient fits one word
	always_comb begin
		diff   = {1'b0, rem_q, quo_q[afade_pkg::DATA_W-1]} - {2'b00, den_q};
		borrow = diff[afade_pkg::DATA_W+1];
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q <= dividend[2*afade_pkg::DATA_W-1:afade_pkg::DATA_W];
			quo_q <= dividend[afade_pkg::DATA_W-1:0];
			den_q <= divisor;
		end else if (ctl.step) begin
			if (borrow) begin
				rem_q <= {rem_q[afade_pkg::DATA_W-2:0], quo_q[afade_pkg::DATA_W-1]};
			end else begin
				rem_q <= diff[afade_pkg::DATA_W-1:0];
			end
			quo_q <= {quo_q[afade_pkg::DATA_W-2:0], ~borrow};
		end
	end

	assign quotient = quo_q;

endmodule

/* sv/audio_linear_fade_core.sv */
// Channel  Modport  Payload                       Meaning
// cfg      sink     index, data                   register write request
// audio    sink     sample_in                     one sample request
// faded    source   sample_out, last              faded sample request
//
// From acceptance, a sample takes four steps to work out the gain, 32 bit-serial multiply steps,
// one select, 32 divide steps and one to load the result into the output register; the serial
// multiply and divide set how long this takes, and a sample is taken only from the idle state.
// A new sample is taken once the previous one has reached the output register, even while that
// result still waits for faded.ready. cfg.ready is high.
// arst_n clears the length registers, the stream position and the control state.
module audio_linear_fade_core (
	input  logic                clk,
	input  logic                arst_n,
	afade_cfg_if.sink           cfg,
	afade_in_if.sink            audio,
	afade_out_if.source         faded
);

	localparam int W = afade_pkg::DATA_W;
	localparam int SB = afade_pkg::SAMPLE_BITS;

	afade_pkg::afade_state_t state_q;

	logic [W-1:0] stream_q;
	logic [W-1:0] fade_in_q;
	logic [W-1:0] fade_out_q;
	logic [W-1:0] position_q;

	logic [afade_pkg::CNT_W-1:0] cnt_q;

	logic [W-1:0] i_q;
	logic [W-1:0] mag_q;
	logic         neg_q;
	logic         last_item_q;
	logic [W-1:0] fi_q;
	logic [W-1:0] fo_q;
	logic [W-1:0] num_a_q;
	logic [W-1:0] den_a_q;
	logic [W:0]   isum_q;
	logic         out_fade_q;
	logic [W-1:0] k_q;
	logic [W-1:0] fnum_q;

	logic         out_valid_q;
	logic [W-1:0] sample_out_q;
	logic         last_q;

	logic                  accept;
	logic signed [SB-1:0]  s_low;
	logic signed [W-1:0]   s_ext;
	logic [W:0]            pos_nxt;
	logic                  pos_last;
	logic                  in_fade;
	logic [W:0]            kdiff;
	logic [W-1:0]          fnum;
	logic                  use_out;
	logic [2*W-1:0]        div_num;
	logic [W-1:0]          div_den;
	logic [W-1:0]          res;
	logic                  out_load;
	logic                  cnt_end;

	logic [2*W-1:0] p_fnum_den;
	logic [2*W-1:0] p_num_fo;
	logic [2*W-1:0] p_mag_num;
	logic [2*W-1:0] p_mag_fnum;
	logic [W-1:0]   quotient;

	afade_pkg::afade_ctl_t mul_ctl;
	afade_pkg::afade_ctl_t div_ctl;

	assign cfg.ready   = 1'b1;
	assign audio.ready = (state_q == afade_pkg::ST_IDLE);
	assign accept      = audio.valid && audio.ready;

	always_comb begin
		s_low    = audio.sample_in[SB-1:0];
		s_ext    = W'(s_low);
		pos_nxt  = {1'b0, position_q} + (W+1)'(1);
		pos_last = (pos_nxt >= {1'b0, stream_q});
		in_fade  = (i_q < fi_q);
		kdiff    = isum_q - {1'b0, stream_q};
		fnum     = (k_q >= fo_q) ? '0 : (fo_q - k_q);
		use_out  = out_fade_q && (p_fnum_den < p_num_fo);
		div_num  = use_out ? p_mag_fnum : p_mag_num;
		div_den  = use_out ? fo_q : den_a_q;
		res      = neg_q ? (~quotient + W'(1)) : quotient;
		out_load = (state_q == afade_pkg::ST_DONE) && (!out_valid_q || faded.ready);
		cnt_end  = (cnt_q == afade_pkg::CNT_W'(afade_pkg::STEPS - 1));
	end

	assign mul_ctl.load = (state_q == afade_pkg::ST_FADE_D);
	assign mul_ctl.step = (state_q == afade_pkg::ST_MUL);
	assign div_ctl.load = (state_q == afade_pkg::ST_SEL);
	assign div_ctl.step = (state_q == afade_pkg::ST_DIV);

	// Cross products for the gain compare, and both candidate sample products
	afade_mul u_mul_fnum_den (
		.clk     (clk),
		.ctl     (mul_ctl),
		.mcand   (fnum),
		.mplier  (den_a_q),
		.product (p_fnum_den)
	);

	afade_mul u_mul_num_fo (
		.clk     (clk),
		.ctl     (mul_ctl),
		.mcand   (num_a_q),
		.mplier  (fo_q),
		.product (p_num_fo)
	);

	afade_mul u_mul_mag_num (
		.clk     (clk),
		.ctl     (mul_ctl),
		.mcand   (mag_q),
		.mplier  (num_a_q),
		.product (p_mag_num)
	);

	afade_mul u_mul_mag_fnum (
		.clk     (clk),
		.ctl     (mul_ctl),
		.mcand   (fnum),
		.mplier  (mag_q),
		.product (p_mag_fnum)
	);

	afade_div u_div (
		.clk      (clk),
		.ctl      (div_ctl),
		.dividend (div_num),
		.divisor  (div_den),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_q   <= '0;
			fade_in_q  <= '0;
			fade_out_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				afade_pkg::REG_STREAM_LENGTH:   stream_q   <= cfg.data;
				afade_pkg::REG_FADE_IN_LENGTH:  fade_in_q  <= cfg.data;
				afade_pkg::REG_FADE_OUT_LENGTH: fade_out_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= afade_pkg::ST_IDLE;
			position_q <= '0;
			cnt_q      <= '0;
		end else begin
			case (state_q)
				afade_pkg::ST_IDLE: begin
					if (accept) begin
						// Restart the stream after its last sample
						position_q <= pos_last ? '0 : pos_nxt[W-1:0];
						state_q    <= afade_pkg::ST_FADE_A;
					end
				end
				afade_pkg::ST_FADE_A: state_q <= afade_pkg::ST_FADE_B;
				afade_pkg::ST_FADE_B: state_q <= afade_pkg::ST_FADE_C;
				afade_pkg::ST_FADE_C: state_q <= afade_pkg::ST_FADE_D;
				afade_pkg::ST_FADE_D: begin
					cnt_q   <= '0;
					state_q <= afade_pkg::ST_MUL;
				end
				afade_pkg::ST_MUL: begin
					cnt_q <= cnt_q + afade_pkg::CNT_W'(1);
					if (cnt_end) begin
						state_q <= afade_pkg::ST_SEL;
					end
				end
				afade_pkg::ST_SEL: begin
					cnt_q   <= '0;
					state_q <= afade_pkg::ST_DIV;
				end
				afade_pkg::ST_DIV: begin
					cnt_q <= cnt_q + afade_pkg::CNT_W'(1);
					if (cnt_end) begin
						state_q <= afade_pkg::ST_DONE;
					end
				end
				afade_pkg::ST_DONE: begin
					if (out_load) begin
						state_q <= afade_pkg::ST_IDLE;
					end
				end
				default: state_q <= afade_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			i_q         <= position_q;
			neg_q       <= s_low[SB-1];
			mag_q       <= s_low[SB-1] ? (~s_ext + W'(1)) : s_ext;
			last_item_q <= pos_last;
		end
		if (state_q == afade_pkg::ST_FADE_A) begin
			// Clamp both fades to the stream length
			fi_q <= (fade_in_q < stream_q) ? fade_in_q : stream_q;
			fo_q <= (fade_out_q < stream_q) ? fade_out_q : stream_q;
		end
		if (state_q == afade_pkg::ST_FADE_B) begin
			num_a_q <= in_fade ? i_q : W'(1);
			den_a_q <= in_fade ? fi_q : W'(1);
			isum_q  <= {1'b0, i_q} + {1'b0, fo_q};
		end
		if (state_q == afade_pkg::ST_FADE_C) begin
			// Position reaches the fade-out once i + fo >= len
			out_fade_q <= (fo_q != '0) && (isum_q >= {1'b0, stream_q});
			k_q        <= kdiff[W-1:0];
		end
		if (state_q == afade_pkg::ST_FADE_D) begin
			fnum_q <= fnum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (faded.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sample_out_q <= res;
			last_q       <= last_item_q;
		end
	end

	assign faded.valid      = out_valid_q;
	assign faded.sample_out = sample_out_q;
	assign faded.last       = last_q;

`ifndef NO_ASSERTIONS
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == afade_pkg::ST_SEL) |-> (div_den != '0))
		else $error("divisor is zero at divide start");

	a_gain_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == afade_pkg::ST_MUL) |-> (num_a_q <= den_a_q) && (fnum_q <= fo_q))
		else $error("gain numerator exceeds denominator");

	a_no_gain_above_unity: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == afade_pkg::ST_DONE) |-> (quotient <= mag_q))
		else $error("faded magnitude exceeds input magnitude");
`endif

endmodule

/* dv/audio_linear_fade_core_test.sv */
`timescale 1ns / 1ps

class fade_gain_scoreboard;

	typedef struct {
		logic [31:0] sample;
		logic        last;
		bit   [31:0] pos;
	} faded_sample_t;

	bit [31:0] stream_len;
	bit [31:0] fade_in_len;
	bit [31:0] fade_out_len;
	bit [31:0] pos;

	faded_sample_t faded_due_q[$];

	int errors;
	int n_samples;
	int n_results;
	int n_ends;
	int n_attenuated;
	int n_past_end;

	function void write_reg(logic [afade_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
		case (idx)
			afade_pkg::REG_STREAM_LENGTH:   stream_len   = val;
			afade_pkg::REG_FADE_IN_LENGTH:  fade_in_len  = val;
			afade_pkg::REG_FADE_OUT_LENGTH: fade_out_len = val;
			default: ;
		endcase
	endfunction

	// Work out the faded sample for the next stream position and queue it
	function void note_sample(logic [31:0] s_in);
		bit [31:0]      len, fi, fo, i, num, den, k, fnum;
		bit [63:0]      raw;
		longint         sv;
		longint         r;
		longint unsigned mag, q;
		faded_sample_t  e;

		len = stream_len;
		fi  = (fade_in_len < len) ? fade_in_len : len;
		fo  = (fade_out_len < len) ? fade_out_len : len;
		i   = pos;
		num = 1;
		den = 1;
		if (i < fi) begin
			num = i;
			den = fi;
		end
		if (fo != 0 && i >= len - fo) begin
			k    = i - (len - fo);
			fnum = (k >= fo) ? 32'd0 : fo - k;
			// keep the smaller of the two gains
			if (64'(fnum) * 64'(den) < 64'(num) * 64'(fo)) begin
				num = fnum;
				den = fo;
			end
		end

		raw = {32'd0, s_in} << (64 - afade_pkg::SAMPLE_BITS);
		sv  = $signed(raw) >>> (64 - afade_pkg::SAMPLE_BITS);
		mag = (sv < 0) ? longint'(-sv) : longint'(sv);
		q   = (mag * 64'(num)) / 64'(den);
		r   = (sv < 0) ? -longint'(q) : longint'(q);

		e.sample = r[31:0];
		e.last   = (64'(i) + 64'd1 >= 64'(len));
		e.pos    = i;
		faded_due_q.push_back(e);

		pos = e.last ? 32'd0 : i + 32'd1;
		n_samples++;
		if (e.last)
			n_ends++;
		if (num != den)
			n_attenuated++;
		if (len != 0 && i >= len)
			n_past_end++;
	endfunction

	function int pending();
		return faded_due_q.size();
	endfunction

	task report(string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		errors++;
	endtask

	task check_faded(logic [31:0] got_sample, logic got_last);
		faded_sample_t e;

		n_results++;
		if (faded_due_q.size() == 0) begin
			report($sformatf("unexpected result sample_out %h last %b", got_sample, got_last));
			return;
		end
		e = faded_due_q.pop_front();
		if (got_sample !== e.sample)
			report($sformatf("position %0d: sample_out %h, expected %h",
				e.pos, got_sample, e.sample));
		if (got_last !== e.last)
			report($sformatf("position %0d: last %b, expected %b", e.pos, got_last, e.last));
	endtask

endclass

module audio_linear_fade_core_test;

	logic clk;
	logic arst_n;

	afade_cfg_if cfg_bus ();
	afade_in_if  audio_bus ();
	afade_out_if faded_bus ();

	audio_linear_fade_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.audio  (audio_bus),
		.faded  (faded_bus)
	);

	fade_gain_scoreboard sb;

	int hold_req;
	int rx_wait;
	int settings;
	bit steady;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(12, 40);
	endfunction

	function automatic logic [31:0] pick_sample();
		case ($urandom_range(0, 7))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2, 3:    return 32'(int'($urandom_range(0, 2000)) - 1000);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] pick_fade(logic [31:0] len);
		case ($urandom_range(0, 5))
			0:       return 32'd0;
			1:       return 32'hFFFF_FFFF;
			2:       return $urandom();
			3:       return len;
			default: return (len > 32'd64) ? len - $urandom_range(0, 8) : $urandom_range(0, len + 3);
		endcase
	endfunction

	// Hold off new samples until every queued result has come back
	task automatic drain();
		audio_bus.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(logic [afade_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= val;
		do @(posedge clk); while (cfg_bus.ready !== 1'b1);
		sb.write_reg(idx, val);
	endtask

	task automatic load_setting(logic [31:0] len, logic [31:0] fi, logic [31:0] fo);
		int first;

		drain();
		first = $urandom_range(0, 2);
		for (int j = 0; j < 3; j++) begin
			case ((first + j) % 3)
				0:       write_reg(afade_pkg::REG_STREAM_LENGTH, len);
				1:       write_reg(afade_pkg::REG_FADE_IN_LENGTH, fi);
				default: write_reg(afade_pkg::REG_FADE_OUT_LENGTH, fo);
			endcase
		end
		// unused index: must leave every register alone
		if ($urandom_range(0, 3) == 0)
			write_reg(afade_pkg::REG_FADE_OUT_LENGTH + 8'($urandom_range(1, 253)), $urandom());
		cfg_bus.valid <= 1'b0;
		settings++;
	endtask

	task automatic send_sample(logic [31:0] s, int gap);
		if (gap > 0) begin
			audio_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		audio_bus.valid     <= 1'b1;
		audio_bus.sample_in <= s;
		do @(posedge clk); while (audio_bus.ready !== 1'b1);
		sb.note_sample(s);
	endtask

	// Result side: check each accepted result, then pick ready for the next edge
	initial begin
		faded_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (faded_bus.valid === 1'b1 && faded_bus.ready === 1'b1)
				sb.check_faded(faded_bus.sample_out, faded_bus.last);
			if (hold_req > 0) begin
				rx_wait  = hold_req;
				hold_req = 0;
			end else if (rx_wait == 0 && !steady && $urandom_range(0, 3) == 0) begin
				rx_wait = pick_gap();
			end
			if (rx_wait > 0) begin
				faded_bus.ready <= 1'b0;
				rx_wait--;
			end else begin
				faded_bus.ready <= 1'b1;
			end
		end
	end

	initial begin
		#4_000_000;
		$display("timeout with %0d results outstanding", sb.pending());
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		logic [31:0] len;
		logic [31:0] fi;
		logic [31:0] fo;
		int          n;
		int          phase;

		sb = new();
		cfg_bus.valid       <= 1'b0;
		cfg_bus.index       <= '0;
		cfg_bus.data        <= '0;
		audio_bus.valid     <= 1'b0;
		audio_bus.sample_in <= '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero stream length straight out of reset: unity gain, every sample last
		send_sample(32'h8000_0000, 0);
		send_sample(32'h7FFF_FFFF, 0);
		send_sample(32'h0000_0000, 1);

		// overlapping fades, twice round the stream
		load_setting(32'd4, 32'd3, 32'd3);
		send_sample(32'h8000_0000, 0);
		send_sample(32'h7FFF_FFFF, 0);
		send_sample(32'hFFFF_FFFF, 0);
		send_sample(32'd12345, 0);
		send_sample(32'd1, 2);
		send_sample(32'hFFFF_FFF9, 0);
		send_sample(32'h7FFF_FFFF, 0);
		send_sample(32'h8000_0000, 0);

		// fade lengths clamped to the stream
		load_setting(32'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_sample(32'h7FFF_FFFF, 0);
		send_sample(32'h8000_0000, 0);
		send_sample(32'h7FFF_FFFF, 0);

		// shorten the stream mid-way so the position sits past the end
		load_setting(32'd8, 32'd0, 32'd2);
		for (int j = 0; j < 5; j++)
			send_sample(32'h7FFF_FFFF - 32'(j), 0);
		load_setting(32'd2, 32'd0, 32'd1);
		send_sample(32'h8000_0000, 0);
		send_sample(32'h4000_0000, 0);

		// widest stream and fade-out
		load_setting(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
		send_sample(32'h8000_0000, 0);
		send_sample(32'h8000_0000, 0);

		phase = 0;
		while (sb.n_samples < 500) begin
			case ($urandom_range(0, 9))
				0:       len = 32'd0;
				1:       len = $urandom();
				2:       len = 32'hFFFF_FFFF;
				default: len = $urandom_range(1, 24);
			endcase
			fi = pick_fade(len);
			fo = pick_fade(len);
			load_setting(len, fi, fo);
			steady = (phase % 7 == 3);
			n = (len != 0 && len <= 24) ? $urandom_range(1, 2 * len + 4) : $urandom_range(2, 12);

			// receiver holds off long enough for the block to back up
			if (phase == 2) begin
				hold_req = 400;
				for (int j = 0; j < 8; j++)
					send_sample(pick_sample(), 0);
			end
			for (int j = 0; j < n; j++) begin
				if (phase == 5 && j == n / 2)
					drain();
				send_sample(pick_sample(), steady ? 0 : pick_gap());
			end
			phase++;
		end

		drain();
		steady = 1'b0;
		repeat (100) @(posedge clk);

		$display("Ran %0d samples over %0d register settings: %0d stream ends, %0d attenuated,",
			sb.n_samples, settings, sb.n_ends, sb.n_attenuated);
		$display("%0d past a shortened end; %0d results checked, %0d mismatches.",
			sb.n_past_end, sb.n_results, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
